// ===== hdl/tsb_pkg.sv =====
// Shared types, operation codes and glyph helpers for the text screen buffer.
package tsb_pkg;

   // Operation codes carried in the request beat.
   localparam logic [2:0] OP_PUT_CHAR    = 3'd0;
   localparam logic [2:0] OP_NEW_LINE    = 3'd1;
   localparam logic [2:0] OP_CLEAR       = 3'd2;
   localparam logic [2:0] OP_MOVE_CURSOR = 3'd3;
   localparam logic [2:0] OP_SHOW_ROW    = 3'd4;

   localparam logic [7:0] SPACE_CHAR         = 8'd32;
   localparam logic [7:0] CURSOR_GLYPH_RESET = 8'd95;

   // Register file: byte address 4*i, so bit 2 selects the register.
   localparam int         CSR_ADDR_WIDTH   = 3;
   localparam logic       REG_CURSOR_GLYPH = 1'b0;

   typedef struct packed {
      logic [2:0]        operation;
      logic [7:0]        ch;
      logic signed [7:0] target_col;
      logic signed [7:0] target_row;
      logic              input_mode;
      logic              blink_on;
   } req_type;

   typedef struct packed {
      logic [7:0] glyph;
      logic [4:0] column;
      logic [1:0] line;
      logic       last;
   } rsp_type;

   // Control characters and the upper half of the byte range display as blanks.
   function automatic logic [7:0] visible_glyph(input logic [7:0] c);
      logic [7:0] g;
      if (c < SPACE_CHAR || c[7]) begin
         g = SPACE_CHAR;
      end else begin
         g = c;
      end
      return g;
   endfunction

endpackage

// ===== hdl/text_screen_buffer_core.sv =====
// Put char without a scroll, move cursor, show row on a clean row and unused codes stay in idle.
// New line to a row that needs no scroll blanks that row; clear blanks all COLUMNS*ROWS cells.
// A scroll (put char past the last cell, new line on the bottom row) moves every row up one,
// then blanks the bottom row. Show row waits out output stalls; each glyph is one cell RAM read.
// Reset is synchronous; afterwards a clearing pass writes spaces over the COLUMNS*ROWS cells,
// one per cycle, during which no request beat is taken.
module text_screen_buffer_core
   import tsb_pkg::*;
#(
   parameter int COLUMNS = 20,
   parameter int ROWS    = 4
)
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  req_type                   req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output rsp_type                   rsp_data,
   input  logic                      psel,
   input  logic                      penable,
   input  logic                      pwrite,
   input  logic [CSR_ADDR_WIDTH-1:0] paddr,
   input  logic [31:0]               pwdata,
   output logic [31:0]               prdata,
   output logic                      pready
);

   localparam int CELLS = COLUMNS * ROWS;
   localparam int AW    = $clog2(CELLS);
   localparam int IW    = $clog2(CELLS + 1);
   localparam int CW    = $clog2(COLUMNS);
   localparam int RW    = (ROWS > 1) ? $clog2(ROWS) : 1;

   typedef enum logic [4:0] {
      ST_IDLE      = 5'b00001,
      ST_FILL      = 5'b00010,
      ST_COPY      = 5'b00100,
      ST_SHOW_RD   = 5'b01000,
      ST_SHOW_DATA = 5'b10000
   } state_type;

   state_type         state_ff, state_in;
   logic [CW-1:0]     cur_col_ff, cur_col_in;
   logic [RW-1:0]     cur_row_ff, cur_row_in;
   logic [ROWS-1:0]   dirty_ff, dirty_in;
   logic [IW-1:0]     idx_ff, idx_in;
   logic [IW-1:0]     fill_end_ff, fill_end_in;
   logic [CW-1:0]     x_ff, x_in;
   logic [RW-1:0]     show_row_ff, show_row_in;
   logic [AW-1:0]     show_base_ff, show_base_in;
   logic              show_cur_ff, show_cur_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_data_ff, rsp_data_in;
   logic [7:0]        rdata_ff;

   logic [7:0]        cells_mem [CELLS];
   logic              wr_en;
   logic [AW-1:0]     wr_addr;
   logic [7:0]        wr_data;
   logic              rd_en;
   logic [AW-1:0]     rd_addr;

   logic [7:0]        cursor_glyph;
   logic [AW-1:0]     cur_addr;
   logic              at_last_col;
   logic              at_last_row;
   logic              rsp_free;
   int                tc_i;
   int                tr_i;
   logic [31:0]       col_wide;
   logic [31:0]       row_wide;

   tsb_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .psel         (psel),
      .penable      (penable),
      .pwrite       (pwrite),
      .paddr        (paddr),
      .pwdata       (pwdata),
      .prdata       (prdata),
      .pready       (pready),
      .cursor_glyph (cursor_glyph)
   );

   assign cur_addr    = AW'(int'(cur_row_ff) * COLUMNS + int'(cur_col_ff));
   assign at_last_col = (int'(cur_col_ff) == COLUMNS - 1);
   assign at_last_row = (int'(cur_row_ff) == ROWS - 1);
   assign rsp_free    = !rsp_valid_ff || !rsp_stall;
   assign tc_i        = int'(req_data.target_col);
   assign tr_i        = int'(req_data.target_row);
   assign col_wide    = 32'(x_ff);
   assign row_wide    = 32'(show_row_ff);

   always_comb begin
      state_in     = state_ff;
      cur_col_in   = cur_col_ff;
      cur_row_in   = cur_row_ff;
      dirty_in     = dirty_ff;
      idx_in       = idx_ff;
      fill_end_in  = fill_end_ff;
      x_in         = x_ff;
      show_row_in  = show_row_ff;
      show_base_in = show_base_ff;
      show_cur_in  = show_cur_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      wr_en        = 1'b0;
      wr_addr      = '0;
      wr_data      = SPACE_CHAR;
      rd_en        = 1'b0;
      rd_addr      = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               case (req_data.operation)
                  OP_PUT_CHAR: begin
                     wr_en               = 1'b1;
                     wr_addr             = cur_addr;
                     wr_data             = req_data.ch;
                     dirty_in[cur_row_ff] = 1'b1;
                     if (at_last_col) begin
                        cur_col_in = '0;
                        if (at_last_row) begin
                           // Past the last cell: scroll, the cursor stays on the bottom row.
                           dirty_in    = '1;
                           idx_in      = IW'(COLUMNS);
                           fill_end_in = IW'(CELLS - 1);
                           state_in    = ST_COPY;
                        end else begin
                           cur_row_in = cur_row_ff + 1'b1;
                        end
                     end else begin
                        cur_col_in = cur_col_ff + 1'b1;
                     end
                  end
                  OP_NEW_LINE: begin
                     cur_col_in = '0;
                     if (at_last_row) begin
                        // The scroll blanks the bottom row, which is the new cursor row.
                        dirty_in    = '1;
                        idx_in      = IW'(COLUMNS);
                        fill_end_in = IW'(CELLS - 1);
                        state_in    = ST_COPY;
                     end else begin
                        cur_row_in                  = cur_row_ff + 1'b1;
                        dirty_in[cur_row_ff + 1'b1] = 1'b1;
                        idx_in      = IW'((int'(cur_row_ff) + 1) * COLUMNS);
                        fill_end_in = IW'((int'(cur_row_ff) + 2) * COLUMNS - 1);
                        state_in    = ST_FILL;
                     end
                  end
                  OP_CLEAR: begin
                     cur_col_in  = '0;
                     cur_row_in  = '0;
                     dirty_in    = '1;
                     idx_in      = '0;
                     fill_end_in = IW'(CELLS - 1);
                     state_in    = ST_FILL;
                  end
                  OP_MOVE_CURSOR: begin
                     if (tc_i < 0) begin
                        cur_col_in = '0;
                     end else if (tc_i >= COLUMNS) begin
                        cur_col_in = CW'(COLUMNS - 1);
                     end else begin
                        cur_col_in = CW'(tc_i);
                     end
                     if (tr_i < 0) begin
                        cur_row_in = '0;
                     end else if (tr_i >= ROWS) begin
                        cur_row_in = RW'(ROWS - 1);
                     end else begin
                        cur_row_in = RW'(tr_i);
                     end
                  end
                  OP_SHOW_ROW: begin
                     if (tr_i >= 0 && tr_i < ROWS) begin
                        if (dirty_ff[RW'(tr_i)] ||
                            (req_data.input_mode && (RW'(tr_i) == cur_row_ff))) begin
                           dirty_in[RW'(tr_i)] = 1'b0;
                           show_row_in  = RW'(tr_i);
                           show_base_in = AW'(tr_i * COLUMNS);
                           show_cur_in  = req_data.input_mode && req_data.blink_on &&
                                          (RW'(tr_i) == cur_row_ff);
                           x_in         = '0;
                           state_in     = ST_SHOW_RD;
                        end
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_COPY: begin
            // Each write stores the cell read in the previous cycle, one row above where it was read.
            if (idx_ff < IW'(CELLS)) begin
               rd_en   = 1'b1;
               rd_addr = idx_ff[AW-1:0];
            end
            if (idx_ff > IW'(COLUMNS)) begin
               wr_en   = 1'b1;
               wr_addr = AW'(int'(idx_ff) - COLUMNS - 1);
               wr_data = rdata_ff;
            end
            if (idx_ff == IW'(CELLS)) begin
               idx_in   = IW'(CELLS - COLUMNS);
               state_in = ST_FILL;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         ST_FILL: begin
            wr_en   = 1'b1;
            wr_addr = idx_ff[AW-1:0];
            wr_data = SPACE_CHAR;
            if (idx_ff == fill_end_ff) begin
               state_in = ST_IDLE;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         ST_SHOW_RD: begin
            rd_en    = 1'b1;
            rd_addr  = show_base_ff + AW'(x_ff);
            state_in = ST_SHOW_DATA;
         end
         ST_SHOW_DATA: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               if (show_cur_ff && (x_ff == cur_col_ff)) begin
                  rsp_data_in.glyph = cursor_glyph;
               end else begin
                  rsp_data_in.glyph = visible_glyph(rdata_ff);
               end
               rsp_data_in.column = col_wide[4:0];
               rsp_data_in.line   = row_wide[1:0];
               rsp_data_in.last   = (int'(x_ff) == COLUMNS - 1);
               if (int'(x_ff) == COLUMNS - 1) begin
                  state_in = ST_IDLE;
               end else begin
                  x_in     = x_ff + 1'b1;
                  state_in = ST_SHOW_RD;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_FILL;
         cur_col_ff   <= '0;
         cur_row_ff   <= '0;
         dirty_ff     <= '1;
         idx_ff       <= '0;
         fill_end_ff  <= IW'(CELLS - 1);
         x_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cur_col_ff   <= cur_col_in;
         cur_row_ff   <= cur_row_in;
         dirty_ff     <= dirty_in;
         idx_ff       <= idx_in;
         fill_end_ff  <= fill_end_in;
         x_ff         <= x_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      show_row_ff  <= show_row_in;
      show_base_ff <= show_base_in;
      show_cur_ff  <= show_cur_in;
      rsp_data_ff  <= rsp_data_in;
   end

   // Cell RAM: one write port and one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         cells_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rdata_ff <= cells_mem[rd_addr];
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== hdl/tsb_csr.sv =====
// Configuration register block: holds the cursor glyph behind the APB-style port.
module tsb_csr
   import tsb_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      psel,
   input  logic                      penable,
   input  logic                      pwrite,
   input  logic [CSR_ADDR_WIDTH-1:0] paddr,
   input  logic [31:0]               pwdata,
   output logic [31:0]               prdata,
   output logic                      pready,
   output logic [7:0]                cursor_glyph
);

   logic [7:0] glyph_ff;
   logic [7:0] glyph_in;
   logic       sel_glyph;

   assign sel_glyph = (paddr[2] == REG_CURSOR_GLYPH);
   assign pready    = 1'b1;

   always_comb begin
      glyph_in = glyph_ff;
      if (psel && penable && pwrite && pready && sel_glyph) begin
         glyph_in = pwdata[7:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         glyph_ff <= CURSOR_GLYPH_RESET;
      end else begin
         glyph_ff <= glyph_in;
      end
   end

   assign prdata       = sel_glyph ? {24'd0, glyph_ff} : 32'd0;
   assign cursor_glyph = glyph_ff;

endmodule

// ===== hdl/tsb_checker.sv =====
// Port-level checks for the text screen buffer, bound to the top level.
module tsb_checker
   import tsb_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_stall,
   input req_type req_data,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);

   // The clearing pass holds off requests straight after reset.
   assert property (@(posedge clock) disable iff (reset) $past(reset) |-> req_stall)
      else $error("request taken during the clearing pass after reset");

   // Only show row produces beats on the result channel.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_data.operation != OP_SHOW_ROW && !rsp_valid)
      |=> !rsp_valid)
      else $error("result beat from an operation that shows nothing");

   // Clear walks the whole buffer, so the next request must wait.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_data.operation == OP_CLEAR) |=> req_stall)
      else $error("request taken while the screen is being cleared");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_data)))
      else $error("stalled result beat changed or was dropped");

endmodule

bind text_screen_buffer_core tsb_checker u_tsb_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

// ===== tb/tb.sv =====
// Self-checking testbench for the text screen buffer core with a built-in screen predictor.
`timescale 1ns / 1ps

module tb;
   import tsb_pkg::*;

   localparam int COLUMNS = 20;
   localparam int ROWS    = 4;
   localparam int CELLS   = COLUMNS * ROWS;
   localparam int RANDOM_ITEMS_PER_PHASE = 125;
   localparam int QUIET_CYCLES = 150;
   localparam int HOLD_OFF_CYCLES = 400;
   localparam logic [2:0] OP_RESERVED_LO = 3'd5;
   localparam logic [2:0] OP_RESERVED_HI = 3'd7;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   req_type                   req_data = '0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   rsp_type                   rsp_data;
   logic                      psel = 1'b0;
   logic                      penable = 1'b0;
   logic                      pwrite = 1'b0;
   logic [CSR_ADDR_WIDTH-1:0] paddr = '0;
   logic [31:0]               pwdata = '0;
   logic [31:0]               prdata;
   logic                      pready;

   // Screen model kept in step with accepted request beats.
   logic [7:0] screen_cells [0:CELLS-1];
   logic       row_stale [0:ROWS-1];
   int         cur_col;
   int         cur_row;
   logic [7:0] glyph_setting;

   req_type    pending_cmds [$];
   rsp_type    expected_glyphs [$];
   int         gap_left = 0;
   int         stall_left = 0;
   int         run_left = 0;
   logic       hold_off = 1'b0;
   int         mismatches = 0;
   int         beats_taken = 0;
   int         glyphs_checked = 0;
   int         scrolls_seen = 0;
   int         settings_used = 0;

   always #4 clock = ~clock;

   text_screen_buffer_core #(.COLUMNS(COLUMNS), .ROWS(ROWS)) i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   task automatic note_mismatch(input string msg);
      mismatches++;
      $display("MISMATCH at %0t: %s", $realtime, msg);
   endtask

   task automatic reset_screen();
      for (int i = 0; i < CELLS; i++) screen_cells[i] = SPACE_CHAR;
      for (int r = 0; r < ROWS; r++) row_stale[r] = 1'b1;
      cur_col = 0;
      cur_row = 0;
      glyph_setting = CURSOR_GLYPH_RESET;
   endtask

   task automatic scroll_screen();
      for (int i = 0; i < CELLS - COLUMNS; i++) screen_cells[i] = screen_cells[i + COLUMNS];
      for (int i = CELLS - COLUMNS; i < CELLS; i++) screen_cells[i] = SPACE_CHAR;
      for (int r = 0; r < ROWS; r++) row_stale[r] = 1'b1;
      if (cur_row > 0) cur_row--;
      scrolls_seen++;
   endtask

   // Applies one command to the screen model and queues the glyph beats it should emit.
   task automatic predict_screen_op(input req_type cmd);
      int pos;
      int tc;
      int tr;
      logic [7:0] g;
      tc = cmd.target_col;
      tr = cmd.target_row;
      case (cmd.operation)
         OP_PUT_CHAR: begin
            pos = cur_row * COLUMNS + cur_col;
            if (pos >= CELLS) pos = CELLS - 1;
            row_stale[pos / COLUMNS] = 1'b1;
            screen_cells[pos] = cmd.ch;
            pos++;
            if (pos >= CELLS) begin
               scroll_screen();
               pos -= COLUMNS;
            end
            cur_col = pos % COLUMNS;
            cur_row = pos / COLUMNS;
         end
         OP_NEW_LINE: begin
            cur_col = 0;
            cur_row++;
            if (cur_row >= ROWS) begin
               cur_row = ROWS;
               scroll_screen();
            end
            for (int x = 0; x < COLUMNS; x++) screen_cells[cur_row * COLUMNS + x] = SPACE_CHAR;
            row_stale[cur_row] = 1'b1;
         end
         OP_CLEAR: begin
            for (int i = 0; i < CELLS; i++) screen_cells[i] = SPACE_CHAR;
            for (int r = 0; r < ROWS; r++) row_stale[r] = 1'b1;
            cur_col = 0;
            cur_row = 0;
         end
         OP_MOVE_CURSOR: begin
            cur_col = (tc < 0) ? 0 : (tc >= COLUMNS) ? COLUMNS - 1 : tc;
            cur_row = (tr < 0) ? 0 : (tr >= ROWS) ? ROWS - 1 : tr;
         end
         OP_SHOW_ROW: begin
            if (tr >= 0 && tr < ROWS &&
                (row_stale[tr] || (cmd.input_mode && tr == cur_row))) begin
               for (int x = 0; x < COLUMNS; x++) begin
                  g = screen_cells[tr * COLUMNS + x];
                  if (g < SPACE_CHAR || g >= 8'd128) g = SPACE_CHAR;
                  if (x == cur_col && tr == cur_row && cmd.input_mode && cmd.blink_on)
                     g = glyph_setting;
                  expected_glyphs.push_back('{glyph: g, column: 5'(x), line: 2'(tr),
                                              last: (x == COLUMNS - 1)});
               end
               row_stale[tr] = 1'b0;
            end
         end
         default: ;
      endcase
   endtask

   function automatic req_type make_cmd(input logic [2:0] op, input logic [7:0] c,
                                        input int col, input int row,
                                        input logic edit, input logic blink);
      req_type cmd;
      cmd.operation  = op;
      cmd.ch         = c;
      cmd.target_col = 8'(col);
      cmd.target_row = 8'(row);
      cmd.input_mode = edit;
      cmd.blink_on   = blink;
      return cmd;
   endfunction

   // Mostly typing with line breaks and frequent row refreshes; a little noise.
   function automatic req_type random_cmd();
      req_type cmd;
      int pick;
      cmd = req_type'($urandom);
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
         cmd.operation = OP_PUT_CHAR;
         if ($urandom_range(0, 4) != 0) cmd.ch = 8'($urandom_range(32, 126));
      end else if (pick < 50) begin
         cmd.operation = OP_NEW_LINE;
      end else if (pick < 53) begin
         cmd.operation = OP_CLEAR;
      end else if (pick < 63) begin
         cmd.operation = OP_MOVE_CURSOR;
         if ($urandom_range(0, 9) < 7) begin
            cmd.target_col = 8'($urandom_range(0, COLUMNS - 1));
            cmd.target_row = 8'($urandom_range(0, ROWS - 1));
         end
      end else if (pick < 97) begin
         cmd.operation = OP_SHOW_ROW;
         if ($urandom_range(0, 9) != 0) cmd.target_row = 8'($urandom_range(0, ROWS - 1));
      end else begin
         cmd.operation = 3'($urandom_range(OP_RESERVED_LO, OP_RESERVED_HI));
      end
      return cmd;
   endfunction

   function automatic int pick_idle();
      int pick;
      pick = $urandom_range(0, 9);
      if (pick < 5) return 0;
      if (pick < 9) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Request driver: predicts each accepted beat, then offers the next one after a random, possibly empty gap.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         gap_left  <= 0;
      end else begin
         if (req_valid && !req_stall) begin
            predict_screen_op(req_data);
            beats_taken++;
         end
         if (!req_valid || !req_stall) begin
            if (gap_left > 0) begin
               gap_left  <= gap_left - 1;
               req_valid <= 1'b0;
            end else if (pending_cmds.size() > 0) begin
               req_data  <= pending_cmds.pop_front();
               req_valid <= 1'b1;
               gap_left  <= pick_idle();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Glyph monitor: checks every accepted beat and stalls the output at random.
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         rsp_stall  <= 1'b0;
         stall_left <= 0;
         run_left   <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            glyphs_checked++;
            if (expected_glyphs.size() == 0) begin
               note_mismatch($sformatf("glyph beat %0d with nothing expected", rsp_data.glyph));
            end else begin
               want = expected_glyphs.pop_front();
               if (rsp_data.glyph !== want.glyph)
                  note_mismatch($sformatf("glyph %0d, expected %0d (row %0d col %0d)",
                                          rsp_data.glyph, want.glyph, want.line, want.column));
               if (rsp_data.column !== want.column)
                  note_mismatch($sformatf("column %0d, expected %0d",
                                          rsp_data.column, want.column));
               if (rsp_data.line !== want.line)
                  note_mismatch($sformatf("line %0d, expected %0d", rsp_data.line, want.line));
               if (rsp_data.last !== want.last)
                  note_mismatch($sformatf("last %0d, expected %0d (col %0d)",
                                          rsp_data.last, want.last, want.column));
            end
         end
         if (hold_off) begin
            rsp_stall <= 1'b1;
         end else if (stall_left > 0) begin
            rsp_stall  <= 1'b1;
            stall_left <= stall_left - 1;
         end else if (run_left > 0) begin
            rsp_stall <= 1'b0;
            run_left  <= run_left - 1;
         end else begin
            rsp_stall  <= 1'b0;
            run_left   <= $urandom_range(0, 40);
            stall_left <= pick_idle();
         end
      end
   end

   // One long output hold-off early in the random traffic, so that the core backs up.
   initial begin
      while (reset || beats_taken < 60) @(posedge clock);
      hold_off <= 1'b1;
      repeat (HOLD_OFF_CYCLES) @(posedge clock);
      hold_off <= 1'b0;
   end

   task automatic write_cursor_glyph(input logic [7:0] value);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {REG_CURSOR_GLYPH, 2'b00};
      pwdata  <= 32'(value);
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      glyph_setting = value;
      settings_used++;
   endtask

   // Waits until every queued beat has been taken and every glyph has come back.
   task automatic wait_until_idle();
      while (pending_cmds.size() != 0 || req_valid || expected_glyphs.size() != 0)
         @(posedge clock);
      repeat (QUIET_CYCLES) @(posedge clock);
   endtask

   initial begin
      logic [7:0] settings [4];
      reset_screen();
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      // Leave room for the clearing pass that follows reset.
      repeat (CELLS + 20) @(posedge clock);
      write_cursor_glyph(8'h2A);

      // Cursor display on and off, byte filtering, rows out of range, clamping and scrolls.
      pending_cmds.push_back(make_cmd(OP_SHOW_ROW, 8'h00, 0, 0, 1'b1, 1'b1));
      pending_cmds.push_back(make_cmd(OP_SHOW_ROW, 8'h00, 0, 0, 1'b0, 1'b1));
      pending_cmds.push_back(make_cmd(OP_SHOW_ROW, 8'h00, 0, 0, 1'b1, 1'b0));
      pending_cmds.push_back(make_cmd(OP_PUT_CHAR, 8'h41, 0, 0, 1'b0, 1'b0));
      pending_cmds.push_back(make_cmd(OP_PUT_CHAR, 8'h00, 0, 0, 1'b0, 1'b0));
      pending_cmds.push_back(make_cmd(OP_PUT_CHAR, 8'h1F, 0, 0, 1'b0, 1'b0));
      pending_cmds.push_back(make_cmd(OP_PUT_CHAR, 8'h7F, 0, 0, 1'b0, 1'b0));
      pending_cmds.push_back(make_cmd(OP_PUT_CHAR, 8'h80, 0, 0, 1'b0, 1'b0));
      pending_cmds.push_back(make_cmd(OP_PUT_CHAR, 8'hFF, 0, 0, 1'b0, 1'b0));
      pending_cmds.push_back(make_cmd(OP_PUT_CHAR, SPACE_CHAR, 0, 0, 1'b0, 1'b0));
      pending_cmds.push_back(make_cmd(OP_SHOW_ROW, 8'h00, 0, 0, 1'b1, 1'b1));
      pending_cmds.push_back(make_cmd(OP_SHOW_ROW, 8'h00, 0, -128, 1'b1, 1'b1));
      pending_cmds.push_back(make_cmd(OP_SHOW_ROW, 8'h00, 0, ROWS, 1'b1, 1'b1));
      pending_cmds.push_back(make_cmd(OP_SHOW_ROW, 8'h00, 0, 127, 1'b1, 1'b1));
      pending_cmds.push_back(make_cmd(OP_MOVE_CURSOR, 8'h00, -128, -128, 1'b0, 1'b0));
      pending_cmds.push_back(make_cmd(OP_MOVE_CURSOR, 8'h00, 127, 127, 1'b0, 1'b0));
      pending_cmds.push_back(make_cmd(OP_PUT_CHAR, 8'h5A, 0, 0, 1'b0, 1'b0));
      pending_cmds.push_back(make_cmd(OP_SHOW_ROW, 8'h00, 0, ROWS - 1, 1'b0, 1'b0));
      pending_cmds.push_back(make_cmd(OP_SHOW_ROW, 8'h00, 0, 2, 1'b0, 1'b0));
      pending_cmds.push_back(make_cmd(OP_MOVE_CURSOR, 8'h00, 5, ROWS - 1, 1'b0, 1'b0));
      pending_cmds.push_back(make_cmd(OP_NEW_LINE, 8'h00, 0, 0, 1'b0, 1'b0));
      pending_cmds.push_back(make_cmd(OP_MOVE_CURSOR, 8'h00, 0, 1, 1'b0, 1'b0));
      pending_cmds.push_back(make_cmd(OP_NEW_LINE, 8'h00, 0, 0, 1'b0, 1'b0));
      pending_cmds.push_back(make_cmd(OP_SHOW_ROW, 8'h00, 0, 2, 1'b1, 1'b1));
      pending_cmds.push_back(make_cmd(OP_CLEAR, 8'h00, 0, 0, 1'b0, 1'b0));
      pending_cmds.push_back(make_cmd(OP_SHOW_ROW, 8'h00, 0, 1, 1'b0, 1'b0));
      pending_cmds.push_back(make_cmd(OP_RESERVED_LO, 8'h41, 3, 3, 1'b1, 1'b1));
      pending_cmds.push_back(make_cmd(OP_RESERVED_HI, 8'h41, 3, 3, 1'b1, 1'b1));
      wait_until_idle();

      settings[0] = 8'h00;
      settings[1] = 8'hFF;
      settings[2] = 8'($urandom);
      settings[3] = CURSOR_GLYPH_RESET;
      foreach (settings[s]) begin
         write_cursor_glyph(settings[s]);
         for (int n = 0; n < RANDOM_ITEMS_PER_PHASE; n++) pending_cmds.push_back(random_cmd());
         wait_until_idle();
      end

      $display("Run covered %0d request beats and %0d glyph beats, with %0d scrolls",
               beats_taken, glyphs_checked, scrolls_seen);
      $display("under %0d cursor glyph settings and one long output hold-off.", settings_used);
      if (mismatches == 0 && expected_glyphs.size() == 0) begin
         $display("text_screen_buffer_core: match");
      end else begin
         $display("text_screen_buffer_core: mismatch");
      end
      $finish;
   end

   initial begin
      #32_000_000;
      $display("Timed out with %0d glyph beats still expected.", expected_glyphs.size());
      $display("text_screen_buffer_core: mismatch");
      $finish;
   end

endmodule
